FILE: rtl/siml_pkg.sv
// ---------------------------------------------------------------------------
// siml_pkg: shared types and codes of the sorted list insert and merge unit
// Holds the channel payload structs, operation codes and result status codes.
// ---------------------------------------------------------------------------
package siml_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_INS_FIRST  = 2'd0;
  localparam logic [1:0] OP_INS_SECOND = 2'd1;
  localparam logic [1:0] OP_MERGE      = 2'd2;

  // Status codes of a result transaction
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_MERGED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // List select carried in from_list
  localparam logic LIST_FIRST  = 1'b0;
  localparam logic LIST_SECOND = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] value_out;
    logic        from_list;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

endpackage

FILE: rtl/siml_ram.sv
// ---------------------------------------------------------------------------
// siml_ram: generic simple dual-port RAM
// One write port and one read port; read data registered.
// ---------------------------------------------------------------------------
module siml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sorted_insert_and_merge_lists_unit.sv
// ---------------------------------------------------------------------------
// sorted_insert_and_merge_lists_unit: two bounded sorted lists, insert/merge
// Keeps two non-increasing lists in RAM; inserts in order, merges on request.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one transaction: insert
//   into list one, insert into list two, or merge. Code 3 is taken and
//   ignored. Output channel (out_valid/out_ready/out_data) returns results.
//   An insert gives one result (inserted or dropped on a full list). A merge
//   gives one result per stored value, largest first, with last on the final
//   one, or a single nothing-to-merge result; both lists are then empty.
// Timing:
//   An insert walks its list from the tail past the entries smaller than the
//   new value, one entry per cycle, through the single read and single write
//   port of that list's RAM, then passes its result to the output register;
//   the next transaction is taken only after that result loads. A dropped
//   insert or an empty merge goes straight to its result. A merge first reads
//   the heads of both lists, emits one value per cycle while the output
//   register is free and takes the next transaction after its last result
//   loads.
// Reset: rst (synchronous) empties both lists and clears the output valid.
// Stall: while out_ready is low the current result holds and the next waits.
// ---------------------------------------------------------------------------
module sorted_insert_and_merge_lists_unit #(
  parameter int LIST_DEPTH = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  siml_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output siml_pkg::out_item_t out_data
);

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_HEAD  = 5'b00100,
    S_RESP  = 5'b01000,
    S_MERGE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]      cnt_a, cnt_a_next, cnt_b, cnt_b_next;
  logic [CNT_W-1:0]      ptr_a, ptr_a_next, ptr_b, ptr_b_next;
  logic [IDX_W-1:0]      scan_idx, scan_idx_next;
  logic [VALUE_BITS-1:0] ins_val, ins_val_next;
  logic                  ins_sel, ins_sel_next;
  logic [1:0]            res_status, res_status_next;
  logic                  res_from, res_from_next;

  logic                  we;
  logic [IDX_W-1:0]      waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] wdata, rd_a, rd_b, rd_sel, mval;
  logic [31:0]           vin_wide, mval_wide;
  logic [VALUE_BITS-1:0] vin;
  logic [CNT_W-1:0]      tcnt;
  logic                  sel_in;
  logic                  a_has, b_has, take_a, merge_last;
  logic                  out_free, out_load;
  siml_pkg::out_item_t   load_data;

  // Fit the input value to the stored width
  assign vin_wide = 32'(in_data.value_in);
  assign vin      = vin_wide[VALUE_BITS-1:0];

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Merge head selection: list one wins only when strictly greater
  assign a_has      = (ptr_a < cnt_a);
  assign b_has      = (ptr_b < cnt_b);
  assign take_a     = a_has && (!b_has || (rd_a > rd_b));
  assign mval       = take_a ? rd_a : rd_b;
  assign mval_wide  = 32'(mval);
  assign merge_last = take_a ? ((ptr_a + CNT_W'(1) == cnt_a) && !b_has)
                             : ((ptr_b + CNT_W'(1) == cnt_b) && !a_has);

  assign sel_in = (in_data.operation == siml_pkg::OP_INS_SECOND);
  assign tcnt   = sel_in ? cnt_b : cnt_a;
  assign rd_sel = ins_sel ? rd_b : rd_a;

  // Next-state and RAM control
  always_comb begin
    state_next      = state;
    cnt_a_next      = cnt_a;
    cnt_b_next      = cnt_b;
    ptr_a_next      = ptr_a;
    ptr_b_next      = ptr_b;
    scan_idx_next   = scan_idx;
    ins_val_next    = ins_val;
    ins_sel_next    = ins_sel;
    res_status_next = res_status;
    res_from_next   = res_from;
    we              = 1'b0;
    waddr           = '0;
    wdata           = ins_val;
    out_load        = 1'b0;
    load_data       = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.operation) inside
            siml_pkg::OP_INS_FIRST, siml_pkg::OP_INS_SECOND: begin
              ins_val_next  = vin;
              ins_sel_next  = sel_in;
              res_from_next = sel_in;
              if (tcnt == CNT_W'(LIST_DEPTH)) begin
                res_status_next = siml_pkg::ST_DROPPED;
                state_next      = S_RESP;
              end else if (tcnt == '0) begin
                state_next = S_HEAD;
              end else begin
                scan_idx_next = IDX_W'(tcnt - CNT_W'(1));
                state_next    = S_SCAN;
              end
            end
            siml_pkg::OP_MERGE: begin
              if (cnt_a == '0 && cnt_b == '0) begin
                res_status_next = siml_pkg::ST_EMPTY;
                res_from_next   = siml_pkg::LIST_FIRST;
                state_next      = S_RESP;
              end else begin
                ptr_a_next = '0;
                ptr_b_next = '0;
                state_next = S_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Shift one entry down per cycle until the slot is found
        we    = 1'b1;
        waddr = scan_idx + IDX_W'(1);
        if (rd_sel >= ins_val) begin
          wdata           = ins_val;
          res_status_next = siml_pkg::ST_INSERTED;
          state_next      = S_RESP;
          if (ins_sel) cnt_b_next = cnt_b + CNT_W'(1);
          else         cnt_a_next = cnt_a + CNT_W'(1);
        end else begin
          wdata = rd_sel;
          if (scan_idx == '0) begin
            state_next = S_HEAD;
          end else begin
            scan_idx_next = scan_idx - IDX_W'(1);
          end
        end
      end

      S_HEAD: begin
        we              = 1'b1;
        waddr           = '0;
        wdata           = ins_val;
        res_status_next = siml_pkg::ST_INSERTED;
        state_next      = S_RESP;
        if (ins_sel) cnt_b_next = cnt_b + CNT_W'(1);
        else         cnt_a_next = cnt_a + CNT_W'(1);
      end

      S_RESP: begin
        if (out_free) begin
          out_load            = 1'b1;
          load_data.from_list = res_from;
          load_data.status    = res_status;
          load_data.last      = 1'b1;
          state_next          = S_IDLE;
        end
      end

      S_MERGE: begin
        if (out_free) begin
          out_load            = 1'b1;
          load_data.value_out = mval_wide[15:0];
          load_data.from_list = take_a ? siml_pkg::LIST_FIRST : siml_pkg::LIST_SECOND;
          load_data.status    = siml_pkg::ST_MERGED;
          load_data.last      = merge_last;
          if (take_a) ptr_a_next = ptr_a + CNT_W'(1);
          else        ptr_b_next = ptr_b + CNT_W'(1);
          if (merge_last) begin
            cnt_a_next = '0;
            cnt_b_next = '0;
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Read addresses follow the next scan index or the next merge heads
  assign raddr_a = (state_next == S_SCAN) ? scan_idx_next : ptr_a_next[IDX_W-1:0];
  assign raddr_b = (state_next == S_SCAN) ? scan_idx_next : ptr_b_next[IDX_W-1:0];

  siml_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (LIST_DEPTH)
  ) u_ram_first (
    .clk   (clk),
    .we    (we && !ins_sel),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  siml_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (LIST_DEPTH)
  ) u_ram_second (
    .clk   (clk),
    .we    (we && ins_sel),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt_a <= '0;
      cnt_b <= '0;
      ptr_a <= '0;
      ptr_b <= '0;
    end else begin
      state <= state_next;
      cnt_a <= cnt_a_next;
      cnt_b <= cnt_b_next;
      ptr_a <= ptr_a_next;
      ptr_b <= ptr_b_next;
    end
  end

  // Working payload of the current transaction
  always_ff @(posedge clk) begin
    scan_idx   <= scan_idx_next;
    ins_val    <= ins_val_next;
    ins_sel    <= ins_sel_next;
    res_status <= res_status_next;
    res_from   <= res_from_next;
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= load_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_a <= CNT_W'(LIST_DEPTH)) && (cnt_b <= CNT_W'(LIST_DEPTH)))
    else $error("list count above depth");

  a_merge_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (a_has || b_has))
    else $error("merge running with both lists exhausted");

  a_merge_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE && out_load && merge_last) |=> (cnt_a == '0 && cnt_b == '0))
    else $error("lists not emptied after merge");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CNT_W'(scan_idx) < (ins_sel ? cnt_b : cnt_a)))
    else $error("scan index outside list");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded over a pending result");
`endif

endmodule
